// ----- design/esuts_pkg.sv -----
// ----------------------------------------------------------------------------
// esuts_pkg
// Shared types, register codes and cosine helpers for the swing-up torque
// selector.
// ----------------------------------------------------------------------------
package esuts_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENDULUM_MASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PENDULUM_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ANGLE   = 3'd4;

  // reset values
  localparam logic [15:0] GRAVITY_RST         = 16'd20084;
  localparam logic [15:0] PENDULUM_MASS_RST   = 16'd4915;
  localparam logic [15:0] PENDULUM_LENGTH_RST = 16'd9699;
  localparam logic [14:0] MAX_TORQUE_RST      = 15'd4096;
  localparam logic [14:0] CAPTURE_ANGLE_RST   = 15'd2867;

  // pi in Q30 and the quarter-wave series coefficients
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint CA_Q30  = 64'sd1324675879;
  localparam longint CB_Q30  = 64'sd272375560;
  localparam longint CC_Q30  = 64'sd22401960;
  localparam longint CD_Q30  = 64'sd987049;

  // Q14 unity of the cosine
  localparam logic signed [16:0] COS_ONE = 17'sd16384;

  typedef struct packed {
    logic [15:0] gravity;
    logic [15:0] pendulum_mass;
    logic [15:0] pendulum_length;
    logic [14:0] max_torque;
    logic [14:0] capture_angle;
  } cfg_t;

  // cos(f/16384 * pi/2) in Q14, f in [0,16384]
  function automatic longint cos_quarter(longint f);
    longint z;
    longint z2;
    longint r;
    longint v;
    z  = f <<< 16;
    z2 = (z * z) >>> 30;
    r  = CD_Q30;
    r  = CC_Q30 - ((z2 * r) >>> 30);
    r  = CB_Q30 - ((z2 * r) >>> 30);
    r  = CA_Q30 - ((z2 * r) >>> 30);
    v  = ONE_Q30 - ((z2 * r) >>> 30);
    if (v < 0) v = 0;
    v = (v + 32768) >>> 16;
    if (v > 16384) v = 16384;
    return v;
  endfunction

  // cosine of a 16 bit turn phase, signed Q14
  function automatic logic signed [15:0] cos_phase(longint ph);
    longint quad;
    longint f;
    longint v;
    quad = ph >>> 14;
    f    = ph & 64'sd16383;
    case (quad)
      64'sd0:  v = cos_quarter(f);
      64'sd1:  v = -cos_quarter(64'sd16384 - f);
      64'sd2:  v = -cos_quarter(f);
      default: v = cos_quarter(64'sd16384 - f);
    endcase
    return 16'(v);
  endfunction

endpackage

// ----- design/esuts_if.sv -----
// ----------------------------------------------------------------------------
// esuts_if
// Valid/ready channels of the swing-up torque selector: sample in, torque
// out, configuration write.
// ----------------------------------------------------------------------------
interface esuts_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pendulum_angle;
  logic signed [15:0] pendulum_rate;
  logic signed [15:0] lqr_torque;

  modport source (output valid, output pendulum_angle, output pendulum_rate,
                  output lqr_torque, input ready);
  modport sink   (input valid, input pendulum_angle, input pendulum_rate,
                  input lqr_torque, output ready);
endinterface

interface esuts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] torque;

  modport source (output valid, output torque, input ready);
  modport sink   (input valid, input torque, output ready);
endinterface

interface esuts_cfg_if;
  import esuts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/esuts_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// esuts_cfg_regs
// Configuration register file; always ready, unknown indexes are ignored.
// ----------------------------------------------------------------------------
module esuts_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  esuts_cfg_if.sink        wr,
  output esuts_pkg::cfg_t  regs
);
  import esuts_pkg::*;

  assign wr.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gravity         <= GRAVITY_RST;
      regs.pendulum_mass   <= PENDULUM_MASS_RST;
      regs.pendulum_length <= PENDULUM_LENGTH_RST;
      regs.max_torque      <= MAX_TORQUE_RST;
      regs.capture_angle   <= CAPTURE_ANGLE_RST;
    end else if (wr.valid) begin
      case (wr.index)
        REG_GRAVITY:         regs.gravity         <= wr.data;
        REG_PENDULUM_MASS:   regs.pendulum_mass   <= wr.data;
        REG_PENDULUM_LENGTH: regs.pendulum_length <= wr.data;
        REG_MAX_TORQUE:      regs.max_torque      <= wr.data[14:0];
        REG_CAPTURE_ANGLE:   regs.capture_angle   <= wr.data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/esuts_cos_rom.sv -----
// ----------------------------------------------------------------------------
// esuts_cos_rom
// Constant cosine table over one turn, signed Q14, registered read.
// ----------------------------------------------------------------------------
module esuts_cos_rom #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  output logic signed [15:0]         data
);
  import esuts_pkg::*;

  logic signed [15:0] rom [DEPTH];

  // entries built at elaboration from the rounded turn phase
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam longint PH_RAW = (longint'(g) * 65536 + DEPTH / 2) / DEPTH;
    localparam longint PH     = (PH_RAW > 65535) ? 65535 : PH_RAW;
    assign rom[g] = cos_phase(PH);
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

// ----- design/energy_swing_up_torque_select.sv -----
// ----------------------------------------------------------------------------
// energy_swing_up_torque_select
// Pipeline: 9 register stages.
// Throughput: one request per cycle; a stall holds each stage in place and
// bubbles still fill, so the rate is set by the output handshake only.
// Reset: synchronous, clears all stage valid bits and loads the register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module energy_swing_up_torque_select #(
  parameter int COS_TABLE_DEPTH = 256,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  esuts_in_if.sink    sample,
  esuts_out_if.source result,
  esuts_cfg_if.sink   cfg
);
  import esuts_pkg::*;

  // angle constants
  localparam longint PI_FIX = (PI_Q30 + (longint'(1) << (29 - ANGLE_FRAC_BITS)))
                              >> (30 - ANGLE_FRAC_BITS);
  localparam longint PERIOD = 2 * PI_FIX;
  localparam longint HALF_P = PERIOD / 2;
  localparam longint KTURN  = (32768 + PI_FIX) / PERIOD + 1;
  localparam longint UOFF   = KTURN * PERIOD - PI_FIX;
  localparam longint UMAX   = 32767 + UOFF;
  localparam longint WMAX   = UMAX * COS_TABLE_DEPTH + HALF_P;

  localparam int TW  = (ANGLE_FRAC_BITS + 4 > 17) ? ANGLE_FRAC_BITS + 4 : 17;
  localparam int UW  = $clog2(UMAX + 1);
  localparam int WW  = $clog2(WMAX + 1);
  localparam int PW  = $clog2(PERIOD + 1);
  localparam int UXW = (UW > PW) ? UW : PW;
  localparam int WXW = (WW > PW) ? WW : PW;
  localparam int QW  = $clog2(UMAX / PERIOD + 2);
  localparam int JW  = $clog2(WMAX / PERIOD + 2);
  localparam int IW0 = $clog2(COS_TABLE_DEPTH + 1);
  localparam int IW  = $clog2(COS_TABLE_DEPTH);
  localparam int NS  = 9;

  // reciprocals of the period
  localparam longint M1 = (longint'(1) << UW) / PERIOD;
  localparam longint M2 = (longint'(1) << WW) / PERIOD;

  localparam logic [UW-1:0] M1_V     = UW'(M1);
  localparam logic [WW-1:0] M2_V     = WW'(M2);
  localparam logic [PW-1:0] PERIOD_V = PW'(PERIOD);

  cfg_t regs;

  esuts_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg),
    .regs (regs)
  );

  // handshake chain
  logic [NS:1]   v;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = result.ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign sample.ready = rdy[1];
  assign result.valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= sample.valid;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: offset from upright, capture test, shifted angle, squared rate, mass-length product
  logic signed [TW-1:0] th;
  logic [TW-1:0]        mag;
  logic [UW-1:0]        u_c;
  logic signed [31:0]   sq;
  logic [31:0]          ml_c;

  logic [UW-1:0]      u1;
  logic               cap1;
  logic signed [15:0] lqr1;
  logic signed [15:0] rate1;
  logic [30:0]        wsq1;
  logic [31:0]        ml1;

  always_comb begin
    th   = TW'(sample.pendulum_angle) - TW'(PI_FIX);
    mag  = th[TW-1] ? TW'(-th) : TW'(th);
    u_c  = UW'(sample.pendulum_angle) + UW'(UOFF);
    sq   = sample.pendulum_rate * sample.pendulum_rate;
    ml_c = regs.pendulum_mass * regs.pendulum_length;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      u1    <= u_c;
      cap1  <= mag < TW'(regs.capture_angle);
      lqr1  <= sample.lqr_torque;
      rate1 <= sample.pendulum_rate;
      wsq1  <= sq[30:0];
      ml1   <= ml_c;
    end
  end

  // stage 2: turn estimate, scaled angle, mass products
  logic [2*UW-1:0] qprod;
  logic [WW-1:0]   w_c;
  logic [47:0]     mll_c;
  logic [47:0]     mgl_c;

  logic [UW-1:0]      u2;
  logic [QW-1:0]      qe2;
  logic [WW-1:0]      w2;
  logic [31:0]        mll2;
  logic [44:0]        mgl2;
  logic               cap2;
  logic signed [15:0] lqr2;
  logic signed [15:0] rate2;
  logic [30:0]        wsq2;

  always_comb begin
    qprod = u1 * M1_V;
    w_c   = WW'(u1) * WW'(COS_TABLE_DEPTH) + WW'(HALF_P);
    mll_c = ml1 * regs.pendulum_length;
    mgl_c = ml1 * regs.gravity;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      u2    <= u1;
      qe2   <= QW'(qprod >> UW);
      w2    <= w_c;
      mll2  <= mll_c[47:16];
      mgl2  <= mgl_c[47:3];
      cap2  <= cap1;
      lqr2  <= lqr1;
      rate2 <= rate1;
      wsq2  <= wsq1;
    end
  end

  // stage 3: turn remainder, index estimate, kinetic term
  logic [QW+PW-1:0] qp;
  logic [2*WW-1:0]  jprod;
  logic [62:0]      kin_c;

  logic [UW-1:0]      qr3;
  logic [QW-1:0]      qe3;
  logic [JW-1:0]      je3;
  logic [WW-1:0]      w3;
  logic [49:0]        kin3;
  logic [44:0]        mgl3;
  logic               cap3;
  logic signed [15:0] lqr3;
  logic signed [15:0] rate3;

  always_comb begin
    qp    = qe2 * PERIOD_V;
    jprod = w2 * M2_V;
    kin_c = mll2 * wsq2;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      qr3   <= u2 - UW'(qp);
      qe3   <= qe2;
      je3   <= JW'(jprod >> WW);
      w3    <= w2;
      kin3  <= kin_c[62:13];
      mgl3  <= mgl2;
      cap3  <= cap2;
      lqr3  <= lqr2;
      rate3 <= rate2;
    end
  end

  // stage 4: correct the turn count, index remainder
  logic [JW+PW-1:0] jp;

  logic [QW-1:0]      q4;
  logic [JW-1:0]      je4;
  logic [WW-1:0]      jr4;
  logic [49:0]        kin4;
  logic [44:0]        mgl4;
  logic               cap4;
  logic signed [15:0] lqr4;
  logic signed [15:0] rate4;

  always_comb begin
    jp = je3 * PERIOD_V;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      q4    <= (UXW'(qr3) >= UXW'(PERIOD)) ? qe3 + QW'(1) : qe3;
      je4   <= je3;
      jr4   <= w3 - WW'(jp);
      kin4  <= kin3;
      mgl4  <= mgl3;
      cap4  <= cap3;
      lqr4  <= lqr3;
      rate4 <= rate3;
    end
  end

  // stage 5: rounded index over all turns, less the whole turns
  logic [JW-1:0] j_c;
  logic [JW-1:0] jdiff;

  logic [IW0-1:0]     idx5;
  logic [49:0]        kin5;
  logic [44:0]        mgl5;
  logic               cap5;
  logic signed [15:0] lqr5;
  logic signed [15:0] rate5;

  always_comb begin
    j_c   = (WXW'(jr4) >= WXW'(PERIOD)) ? je4 + JW'(1) : je4;
    jdiff = j_c - JW'(q4) * JW'(COS_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      idx5  <= IW0'(jdiff);
      kin5  <= kin4;
      mgl5  <= mgl4;
      cap5  <= cap4;
      lqr5  <= lqr4;
      rate5 <= rate4;
    end
  end

  // stage 6: wrap the index into the table
  logic [IW-1:0]      idx6;
  logic [49:0]        kin6;
  logic [44:0]        mgl6;
  logic               cap6;
  logic signed [15:0] lqr6;
  logic signed [15:0] rate6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      idx6  <= (idx5 >= IW0'(COS_TABLE_DEPTH)) ?
               IW'(idx5 - IW0'(COS_TABLE_DEPTH)) : IW'(idx5);
      kin6  <= kin5;
      mgl6  <= mgl5;
      cap6  <= cap5;
      lqr6  <= lqr5;
      rate6 <= rate5;
    end
  end

  // stage 7: cosine lookup
  logic signed [15:0] c7;
  logic [49:0]        kin7;
  logic [44:0]        mgl7;
  logic               cap7;
  logic signed [15:0] lqr7;
  logic signed [15:0] rate7;

  esuts_cos_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .en   (rdy[7]),
    .addr (idx6),
    .data (c7)
  );

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      kin7  <= kin6;
      mgl7  <= mgl6;
      cap7  <= cap6;
      lqr7  <= lqr6;
      rate7 <= rate6;
    end
  end

  // stage 8: potential term and cosine sign
  logic [15:0] omc;
  logic [60:0] pot_c;

  logic [46:0]        pot8;
  logic [49:0]        kin8;
  logic               cpos8;
  logic               cneg8;
  logic               cap8;
  logic signed [15:0] lqr8;
  logic signed [15:0] rate8;

  always_comb begin
    omc   = 16'(COS_ONE - 17'(c7));
    pot_c = mgl7 * omc;
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      pot8  <= pot_c[60:14];
      kin8  <= kin7;
      cpos8 <= (c7 != 16'sd0) && !c7[15];
      cneg8 <= c7[15];
      cap8  <= cap7;
      lqr8  <= lqr7;
      rate8 <= rate7;
    end
  end

  // stage 9: sign of energy error, rate and cosine, torque select
  logic               dpos;
  logic               dneg;
  logic               rnz;
  logic               drive_neg;
  logic signed [15:0] torque_c;

  always_comb begin
    dpos      = kin8 > 50'(pot8);
    dneg      = kin8 < 50'(pot8);
    rnz       = rate8 != 16'sd0;
    drive_neg = (dpos || dneg) && rnz && (cpos8 || cneg8) &&
                !(dneg ^ rate8[15] ^ cneg8);
    if (cap8) begin
      torque_c = lqr8;
    end else if (drive_neg) begin
      torque_c = -signed'({1'b0, regs.max_torque});
    end else begin
      torque_c = signed'({1'b0, regs.max_torque});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      result.torque <= torque_c;
    end
  end

endmodule

// ----- tb/tb_energy_swing_up_torque_select.sv -----
// ----------------------------------------------------------------------------
// tb_energy_swing_up_torque_select
// Self-checking bench for the swing-up torque selector. Samples are driven
// over the valid/ready input channel. Each accepted request is run through
// an independent fixed-point model of the capture test, the cosine lookup and
// the energy sign rule. Every returned torque is checked in order. The run
// goes through four register settings, zero and full scale among them, under
// changing stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb_energy_swing_up_torque_select;
  timeunit 1ns;
  timeprecision 1ps;

  import esuts_pkg::*;

  typedef longint unsigned u64_t;

  // angle scaling and cosine table geometry of the block
  localparam int     ANGLE_FRAC = 12;
  localparam longint COS_DEPTH  = 256;

  // pi in Q30 and quarter-wave series coefficients, Q30
  localparam longint PI_Q30_TB   = 64'sd3373259426;
  localparam longint UNITY_Q30   = 64'sd1073741824;
  localparam longint SERIES_K2   = 64'sd1324675879;
  localparam longint SERIES_K4   = 64'sd272375560;
  localparam longint SERIES_K6   = 64'sd22401960;
  localparam longint SERIES_K8   = 64'sd987049;
  localparam longint COS_UNITY   = 64'sd16384;
  localparam longint HALF_TURN   =
    (PI_Q30_TB + (64'sd1 <<< (29 - ANGLE_FRAC))) >>> (30 - ANGLE_FRAC);

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum int {DRIVE_CAPTURED, DRIVE_POSITIVE, DRIVE_NEGATIVE} drive_kind_t;

  // --------------------------------------------------------------------------
  // expected torque store with its own copy of the registers
  // --------------------------------------------------------------------------
  class torque_scoreboard;
    logic [15:0]        grav;
    logic [15:0]        mass;
    logic [15:0]        len;
    logic [14:0]        torque_max;
    logic [14:0]        capture;
    logic signed [15:0] pending_torques[$];
    int unsigned        mismatches;
    int unsigned        n_checked;
    int unsigned        n_captured;
    int unsigned        n_positive;
    int unsigned        n_negative;

    function new();
      grav       = 16'd20084;
      mass       = 16'd4915;
      len        = 16'd9699;
      torque_max = 15'd4096;
      capture    = 15'd2867;
      mismatches = 0;
      n_checked  = 0;
      n_captured = 0;
      n_positive = 0;
      n_negative = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_GRAVITY:         grav       = val;
        REG_PENDULUM_MASS:   mass       = val;
        REG_PENDULUM_LENGTH: len        = val;
        REG_MAX_TORQUE:      torque_max = val[14:0];
        REG_CAPTURE_ANGLE:   capture    = val[14:0];
        default: ;
      endcase
    endfunction

    // cos(f/16384 * pi/2) in Q14 from the truncated series
    function longint quarter_wave(longint f);
      longint z;
      longint z2;
      longint acc;
      longint v;
      z   = f <<< 16;
      z2  = (z * z) >>> 30;
      acc = SERIES_K8;
      acc = SERIES_K6 - ((z2 * acc) >>> 30);
      acc = SERIES_K4 - ((z2 * acc) >>> 30);
      acc = SERIES_K2 - ((z2 * acc) >>> 30);
      v   = UNITY_Q30 - ((z2 * acc) >>> 30);
      if (v < 0) v = 0;
      v = (v + 32768) >>> 16;
      if (v > COS_UNITY) v = COS_UNITY;
      return v;
    endfunction

    // table cosine of an angle offset, Q14
    function longint table_cos(longint theta);
      longint period;
      longint r;
      longint idx;
      longint ph;
      longint quad;
      longint f;
      period = 2 * HALF_TURN;
      r = theta % period;
      if (r < 0) r = r + period;
      idx = (r * COS_DEPTH + period / 2) / period;
      if (idx >= COS_DEPTH) idx = idx - COS_DEPTH;
      ph = (idx * 65536 + COS_DEPTH / 2) / COS_DEPTH;
      if (ph > 65535) ph = 65535;
      quad = ph >>> 14;
      f    = ph & 64'sd16383;
      case (quad)
        64'sd0:  return quarter_wave(f);
        64'sd1:  return -quarter_wave(COS_UNITY - f);
        64'sd2:  return -quarter_wave(f);
        default: return quarter_wave(COS_UNITY - f);
      endcase
    endfunction

    function int sign_of(longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    // capture test, then the energy pumping sign rule
    function logic signed [15:0] predict_torque(logic signed [15:0] angle,
                                                logic signed [15:0] rate,
                                                logic signed [15:0] lqr,
                                                output drive_kind_t kind);
      longint offset;
      longint offset_mag;
      longint c;
      longint w;
      longint kin;
      longint pot;
      u64_t   mll;
      u64_t   mgl;
      u64_t   w2;
      int     s;
      offset     = longint'(angle) - HALF_TURN;
      offset_mag = (offset < 0) ? -offset : offset;
      if (offset_mag < longint'(capture)) begin
        kind = DRIVE_CAPTURED;
        return lqr;
      end
      c   = table_cos(offset);
      w   = longint'(rate);
      mll = (u64_t'(mass) * u64_t'(len) * u64_t'(len)) >> 16;
      mgl = (u64_t'(mass) * u64_t'(grav) * u64_t'(len)) >> 3;
      w2  = u64_t'(w * w);
      kin = longint'((mll * w2) >> 13);
      pot = -longint'((mgl * u64_t'(COS_UNITY - c)) >> 14);
      s   = sign_of(kin + pot) * sign_of(w) * sign_of(c);
      if (s > 0) begin
        kind = DRIVE_NEGATIVE;
        return 16'(-int'(torque_max));
      end
      kind = DRIVE_POSITIVE;
      return {1'b0, torque_max};
    endfunction

    function void note_sample(logic signed [15:0] angle, logic signed [15:0] rate,
                              logic signed [15:0] lqr);
      drive_kind_t kind;
      pending_torques.push_back(predict_torque(angle, rate, lqr, kind));
      case (kind)
        DRIVE_CAPTURED: n_captured++;
        DRIVE_POSITIVE: n_positive++;
        default:        n_negative++;
      endcase
    endfunction

    function void check_torque(logic signed [15:0] actual);
      logic signed [15:0] expected;
      if (pending_torques.size() == 0) begin
        $error("torque: no request outstanding, actual %0d", actual);
        mismatches++;
        return;
      end
      expected = pending_torques.pop_front();
      n_checked++;
      if (actual !== expected) begin
        $error("torque: expected %0d, actual %0d", expected, actual);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_torques.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and channels
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  torque_scoreboard sb;

  esuts_in_if  sample_if ();
  esuts_out_if result_if ();
  esuts_cfg_if cfg_if ();

  energy_swing_up_torque_select i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // torque receiver with random back-pressure
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      sb.check_torque(result_if.torque);
    end
    result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // hard stop for a hung run
  initial begin
    #2_000_000;
    $display("energy_swing_up_torque_select verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [15:0] angle,
                             input logic signed [15:0] rate,
                             input logic signed [15:0] lqr);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid          <= 1'b1;
    sample_if.pendulum_angle <= angle;
    sample_if.pendulum_rate  <= rate;
    sample_if.lqr_torque     <= lqr;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    sb.note_sample(angle, rate, lqr);
  endtask

  // stop sending and wait for every outstanding torque
  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // full register set, framed by writes to unused indexes
  task automatic set_registers(input logic [15:0] g, input logic [15:0] m,
                               input logic [15:0] l, input logic [15:0] t,
                               input logic [15:0] c);
    logic [CFG_IDX_W-1:0] idx[7];
    logic [15:0]          val[7];
    idx[0] = REG_UNUSED_LO;       val[0] = 16'($urandom);
    idx[1] = REG_GRAVITY;         val[1] = g;
    idx[2] = REG_PENDULUM_MASS;   val[2] = m;
    idx[3] = REG_PENDULUM_LENGTH; val[3] = l;
    idx[4] = REG_MAX_TORQUE;      val[4] = t;
    idx[5] = REG_CAPTURE_ANGLE;   val[5] = c;
    idx[6] = REG_UNUSED_HI;       val[6] = 16'($urandom);
    for (int k = 0; k < 7; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // random sample shaping
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // bias towards upright and the capture boundary
  function automatic logic signed [15:0] pick_angle(longint cap);
    longint a;
    case ($urandom_range(0, 9))
      4, 5: a = HALF_TURN + longint'($urandom_range(0, 2 * cap + 128)) - cap - 64;
      6:    a = HALF_TURN + ($urandom_range(0, 1) ? cap : -cap)
                + longint'($urandom_range(0, 2)) - 1;
      7: begin
        case ($urandom_range(0, 3))
          0:       a = -32768;
          1:       a = 32767;
          2:       a = 0;
          default: a = HALF_TURN;
        endcase
      end
      default: a = longint'($urandom_range(0, 65535)) - 32768;
    endcase
    return clip16(a);
  endfunction

  function automatic logic signed [15:0] pick_rate();
    case ($urandom_range(0, 9))
      6, 7: return clip16(longint'($urandom_range(0, 128)) - 64);
      8:    return 16'sd0;
      9: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // random samples; optional full pause partway through
  task automatic run_random(input int count, input int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      send_sample(pick_angle(longint'(sb.capture)), pick_rate(), 16'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    longint cap;
    int     leftover;
    sb = new();
    sample_if.valid          = 1'b0;
    sample_if.pendulum_angle = '0;
    sample_if.pendulum_rate  = '0;
    sample_if.lqr_torque     = '0;
    cfg_if.valid             = 1'b0;
    cfg_if.index             = '0;
    cfg_if.data              = '0;
    result_if.ready          = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sender mostly busy, receiver mostly stalled
    src_idle_pct  = 19;
    sink_idle_pct = 82;
    cap = longint'(sb.capture);
    // upright and both sides of the capture boundary
    send_sample(clip16(HALF_TURN), 16'sd100, 16'sh8000);
    send_sample(clip16(HALF_TURN + cap - 1), -16'sd5, 16'sh7fff);
    send_sample(clip16(HALF_TURN - cap + 1), 16'sd5, 16'sd1234);
    send_sample(clip16(HALF_TURN + cap), 16'sd300, 16'sd777);
    send_sample(clip16(HALF_TURN - cap), -16'sd300, 16'sd777);
    // hanging down, still and fast
    send_sample(16'sd0, 16'sd0, 16'sd5);
    send_sample(16'sd0, 16'sh7fff, -16'sd5);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    // angle extremes
    send_sample(16'sh8000, 16'sd1000, 16'sh5555);
    send_sample(16'sh7fff, -16'sd1000, -16'sd21846);
    // horizontal, cosine at zero
    send_sample(clip16(HALF_TURN / 2), 16'sd2000, 16'sd0);
    send_sample(clip16(HALF_TURN + HALF_TURN / 2), -16'sd2000, 16'sd0);
    // slow near upright, energy close to the target
    send_sample(clip16(HALF_TURN + cap + 40), 16'sd1, 16'sd0);
    send_sample(clip16(HALF_TURN - cap - 40), -16'sd1, 16'sd0);
    run_random(450, -1);

    // random settings, sender mostly idle; one full pause
    drain_results();
    set_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  {1'($urandom_range(0, 1)), 15'($urandom_range(0, 6000))});
    src_idle_pct  = 82;
    sink_idle_pct = 19;
    run_random(450, 220);

    // zero parameters, zero drive, nothing captured; no stalls
    drain_results();
    set_registers(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_sample(clip16(HALF_TURN), 16'sd0, 16'sd99);
    send_sample(16'sd0, 16'sh7fff, 16'sd99);
    send_sample(16'sh8000, 16'sh8000, 16'sd99);
    send_sample(16'sh7fff, 16'sd1, 16'sd99);
    run_random(100, -1);

    // full scale everywhere
    drain_results();
    set_registers(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
    send_sample(clip16(HALF_TURN - 32767), 16'sd500, 16'sd42);
    send_sample(clip16(HALF_TURN - 32766), 16'sd500, 16'sd42);
    send_sample(16'sh8000, 16'sh7fff, 16'sd42);
    send_sample(16'sh8000, 16'sh8000, 16'sd42);
    run_random(380, -1);

    // drain and let the pipeline settle
    drain_results();
    repeat (20) @(posedge clk);
    leftover = sb.outstanding();
    if (leftover != 0) begin
      $error("torque: %0d expected results never returned", leftover);
    end

    $display("checked %0d torques: %0d passed through, %0d positive drive, %0d negative drive",
             sb.n_checked, sb.n_captured, sb.n_positive, sb.n_negative);
    $display("settings covered: reset, random, all zero, full scale; stalls on both sides");
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("energy_swing_up_torque_select verification clean");
    end else begin
      $display("energy_swing_up_torque_select verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/esuts_pkg.sv
design/esuts_if.sv
design/esuts_cfg_regs.sv
design/esuts_cos_rom.sv
design/energy_swing_up_torque_select.sv
tb/tb_energy_swing_up_torque_select.sv
